>>> rtl/esp3_dfr_pkg.sv
// ---------------------------------------------------------------------------
// esp3_dfr_pkg: shared definitions for the ESP3 radio frame deframer
// Frame constants, result status codes and the byte-wise CRC8 update.
// ---------------------------------------------------------------------------
package esp3_dfr_pkg;

    // Result status code carried with each frame result.
    typedef logic [2:0] t_status;

    localparam t_status ST_4BS_DATA  = 3'd0;
    localparam t_status ST_4BS_TEACH = 3'd1;
    localparam t_status ST_OTHER_ORG = 3'd2;
    localparam t_status ST_HDR_ERR   = 3'd3;
    localparam t_status ST_DATA_ERR  = 3'd4;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] ORG_4BS   = 8'hA5;
    localparam logic [7:0] CRC_POLY  = 8'h07;

    // One byte through the CRC8 (MSB first, no reflection, no final xor).
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/esp3_radio_frame_deframer.sv
// A result is registered: it appears in the output register in the cycle after the byte that ends a frame is accepted.
// One byte per cycle while the input is not held off; the parser state and the CRC8 update together for each byte.
// A byte is held off only while a result waits in the output register and is not taken.
// Reset (synchronous, active low) returns the parser to the sync hunt and clears all captures.
// ---------------------------------------------------------------------------
// esp3_radio_frame_deframer: ESP3 serial frame parser with CRC8 checks
// Hunts for the sync byte, checks header and data CRC8, captures the 4BS
// radio fields and the optional fields, and reports one result per frame.
// ---------------------------------------------------------------------------
module esp3_radio_frame_deframer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output esp3_dfr_pkg::t_status o_frame_status,
    output logic [7:0]            o_packet_type,
    output logic [7:0]            o_radio_org,
    output logic [31:0]           o_data_bytes,
    output logic [31:0]           o_sender_id,
    output logic [7:0]            o_telegram_status,
    output logic                  o_teach_in,
    output logic [7:0]            o_subtelegram_count,
    output logic [31:0]           o_destination_id,
    output logic [7:0]            o_rssi_dbm,
    output logic [7:0]            o_security_level
);
    import esp3_dfr_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_HCRC   = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_DCRC   = 3'd4;

    logic [2:0]  r_phase,     n_phase;
    logic [16:0] r_offset,    n_offset;
    logic [15:0] r_len,       n_len;
    logic [7:0]  r_opt_len,   n_opt_len;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_hcrc,      n_hcrc;
    logic [7:0]  r_dcrc,      n_dcrc;
    logic [7:0]  r_org,       n_org;
    logic [31:0] r_payload,   n_payload;
    logic [31:0] r_sender,    n_sender;
    logic [7:0]  r_tstat,     n_tstat;
    logic [55:0] r_optional,  n_optional;

    logic        r_res_valid;
    logic        emit;
    t_status     emit_status;
    logic        rx_accept;
    logic [16:0] total;
    logic [16:0] offset_inc;
    logic [16:0] opt_index;
    logic        in_optional;

    assign rx_accept  = i_rx_valid && o_rx_ready;
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign total      = {1'b0, r_len} + {9'd0, r_opt_len};
    assign offset_inc = r_offset + 17'd1;
    assign in_optional = r_offset >= {1'b0, r_len};
    assign opt_index  = r_offset - {1'b0, r_len};

    // Parser next state for the byte at the input.
    always_comb begin
        n_phase    = r_phase;
        n_offset   = r_offset;
        n_len      = r_len;
        n_opt_len  = r_opt_len;
        n_type     = r_type;
        n_hcrc     = r_hcrc;
        n_dcrc     = r_dcrc;
        n_org      = r_org;
        n_payload  = r_payload;
        n_sender   = r_sender;
        n_tstat    = r_tstat;
        n_optional = r_optional;
        emit        = 1'b0;
        emit_status = ST_OTHER_ORG;
        case (r_phase)
            PH_HEADER: begin
                n_hcrc = crc8_step(r_hcrc, i_rx_byte);
                case (r_offset[1:0])
                    2'd0:    n_len[15:8] = i_rx_byte;
                    2'd1:    n_len[7:0]  = i_rx_byte;
                    2'd2:    n_opt_len   = i_rx_byte;
                    default: n_type      = i_rx_byte;
                endcase
                if (r_offset >= 17'd3) begin
                    n_offset = '0;
                    n_phase  = PH_HCRC;
                end else begin
                    n_offset = offset_inc;
                end
            end
            PH_HCRC: begin
                if (i_rx_byte != r_hcrc) begin
                    n_phase     = PH_HUNT;
                    emit        = 1'b1;
                    emit_status = ST_HDR_ERR;
                end else begin
                    n_dcrc   = '0;
                    n_offset = '0;
                    n_phase  = (total == 17'd0) ? PH_DCRC : PH_BODY;
                end
            end
            PH_BODY: begin
                n_dcrc = crc8_step(r_dcrc, i_rx_byte);
                // Radio fields sit at fixed offsets from the start of the data.
                if (r_offset == 17'd0) begin
                    n_org = i_rx_byte;
                end
                for (int p = 0; p < 4; p++) begin
                    if (r_offset == 17'(4 - p)) begin
                        n_payload[8*p +: 8] = i_rx_byte;
                    end
                    if (r_offset == 17'(8 - p)) begin
                        n_sender[8*p +: 8] = i_rx_byte;
                    end
                end
                if (r_offset == 17'd9) begin
                    n_tstat = i_rx_byte;
                end
                // Optional bytes are counted from the end of the data part.
                for (int p = 0; p < 7; p++) begin
                    if (in_optional && opt_index == 17'(6 - p)) begin
                        n_optional[8*p +: 8] = i_rx_byte;
                    end
                end
                n_offset = offset_inc;
                if (offset_inc >= total) begin
                    n_phase = PH_DCRC;
                end
            end
            PH_DCRC: begin
                n_phase = PH_HUNT;
                emit    = 1'b1;
                if (i_rx_byte != r_dcrc) begin
                    emit_status = ST_DATA_ERR;
                end else if (r_org == ORG_4BS) begin
                    emit_status = r_payload[3] ? ST_4BS_DATA : ST_4BS_TEACH;
                end else begin
                    emit_status = ST_OTHER_ORG;
                end
            end
            default: begin
                // Sync hunt; a sync byte starts a frame with all captures cleared.
                if (i_rx_byte == SYNC_BYTE) begin
                    n_phase    = PH_HEADER;
                    n_offset   = '0;
                    n_len      = '0;
                    n_opt_len  = '0;
                    n_type     = '0;
                    n_hcrc     = '0;
                    n_dcrc     = '0;
                    n_org      = '0;
                    n_payload  = '0;
                    n_sender   = '0;
                    n_tstat    = '0;
                    n_optional = '0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_offset   <= '0;
            r_len      <= '0;
            r_opt_len  <= '0;
            r_type     <= '0;
            r_hcrc     <= '0;
            r_dcrc     <= '0;
            r_org      <= '0;
            r_payload  <= '0;
            r_sender   <= '0;
            r_tstat    <= '0;
            r_optional <= '0;
        end else if (rx_accept) begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_len      <= n_len;
            r_opt_len  <= n_opt_len;
            r_type     <= n_type;
            r_hcrc     <= n_hcrc;
            r_dcrc     <= n_dcrc;
            r_org      <= n_org;
            r_payload  <= n_payload;
            r_sender   <= n_sender;
            r_tstat    <= n_tstat;
            r_optional <= n_optional;
        end
    end

    // Result valid flag: set by a finished frame, cleared when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (rx_accept && emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload register, loaded from the captures of the finished frame.
    always_ff @(posedge i_clk) begin
        if (rx_accept && emit) begin
            o_frame_status      <= emit_status;
            o_packet_type       <= r_type;
            o_radio_org         <= r_org;
            o_data_bytes        <= r_payload;
            o_sender_id         <= r_sender;
            o_telegram_status   <= r_tstat;
            o_teach_in          <= !r_payload[3];
            o_subtelegram_count <= r_optional[55:48];
            o_destination_id    <= r_optional[47:16];
            o_rssi_dbm          <= r_optional[15:8];
            o_security_level    <= r_optional[7:0];
        end
    end

    assign o_res_valid = r_res_valid;

`ifndef SYNTHESIS
    // A bad header CRC byte produces a header error result.
    a_hdr_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_accept && r_phase == PH_HCRC && i_rx_byte != r_hcrc
        |=> o_res_valid && o_frame_status == ST_HDR_ERR)
        else $error("header CRC error not reported");

    // The data CRC byte always ends the frame with a result.
    a_dcrc_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_accept && r_phase == PH_DCRC |=> o_res_valid && r_phase == PH_HUNT)
        else $error("data CRC byte did not produce a result");

    // The body is only entered with a nonzero length, and stays within it.
    a_body_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> total != 17'd0 && r_offset < total)
        else $error("body offset outside the frame length");

    // A presented result carries a defined status code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_frame_status <= ST_DATA_ERR)
        else $error("undefined frame status");
`endif

endmodule
